[hw/rtl/kmsd_pkg.sv]
// Shared constants, types and state codes of the key matrix scanner.
`timescale 1ns / 1ps
package kmsd_pkg;

  localparam int TIME_W     = 32;
  localparam int DIGIT_W    = 8;
  localparam int N_DIGITS   = TIME_W / DIGIT_W;
  localparam int DCNT_W     = $clog2(N_DIGITS);
  localparam int COL_W      = 16;
  localparam int IDX_W      = 4;
  localparam int DT_W       = 8;
  localparam logic [DT_W-1:0] DT_RESET = 8'd5;
  localparam int ROWS_DEF   = 8;
  localparam int COLS_DEF   = 16;
  localparam int IN_DATA_W  = COL_W + TIME_W;
  localparam int OUT_DATA_W = 2 * IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TIME,
    ST_SCAN
  } scan_state_t;

  // Result of one serial deadline pass.
  typedef struct packed {
    logic done;
    logic expired;
  } dl_res_t;

endpackage

[hw/rtl/key_matrix_scan_debounce.sv]
// Top level of the key matrix scanner with per-row debounce and key events.
`timescale 1ns / 1ps
// Each input word is one scan step for the row under the internal row pointer: the
// decoded column levels (columns at or above COLS are ignored) and a free-running
// millisecond time stamp. A change against the row's last sample restarts the row's
// deadline at time_now + debounce_time; once that deadline is reached in wrapping time
// with the sample unchanged, the sample becomes the stable row. Every column whose
// stable bit differs from what was last reported gives one output word, lowest column
// first, with tlast on the final word of the step; a step with nothing to report gives
// no word. The row pointer then advances and wraps at ROWS. A step first runs the
// deadline arithmetic through a digit-serial unit, 8 bits per cycle, then commits
// the row and walks its columns one per cycle up to the highest changed one, holding
// on a column while the result side stalls; the next word is taken only once the
// step is done. A finished event sits in the output register, so a new step may
// start while it waits. debounce_time resets to 5 and is written through the cfg
// port, which is always ready; write it only while idle.
module key_matrix_scan_debounce
  import kmsd_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: column_bits [15:0], time_now [47:16]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: event_row [3:0], event_column [7:4]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: pressed [0]
  output logic                  out_tuser,
  // out_tlast: last_event
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [DT_W-1:0]       cfg_data
);

  localparam int ROW_IW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_IW = (COLS > 1) ? $clog2(COLS) : 1;

  // Per-row state, each row read only at the row pointer.
  logic [COLS-1:0]   sampled_r  [ROWS];
  logic [COLS-1:0]   stable_r   [ROWS];
  logic [COLS-1:0]   reported_r [ROWS];
  logic              pending_r  [ROWS];
  logic [TIME_W-1:0] deadline_r [ROWS];

  scan_state_t       state_r, state_nxt;
  logic [ROW_IW-1:0] row_ptr_r, row_ptr_nxt;
  logic [DT_W-1:0]   dt_r;
  logic [COLS-1:0]   col_r;
  logic              changed_r;
  logic [COLS-1:0]   diff_sr_r, diff_sr_nxt;
  logic [COLS-1:0]   stab_sr_r, stab_sr_nxt;
  logic [COL_IW-1:0] col_cnt_r, col_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_row_r;
  logic [IDX_W-1:0]  out_col_r;
  logic              out_press_r;
  logic              out_last_r;

  logic              in_acc;
  logic [COLS-1:0]   col_in;
  dl_res_t           dl_res;
  logic [TIME_W-1:0] dl_deadline;
  logic              commit;
  logic              passed;
  logic [COLS-1:0]   stable_new;
  logic [COLS-1:0]   diff_new;
  logic [COLS-1:0]   diff_rest;
  logic              out_free;
  logic              scan_step;
  logic              out_load;
  logic [ROW_IW-1:0] row_next;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign col_in    = in_tdata[COLS-1:0];

  kmsd_deadline_unit u_deadline (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc),
    .now_i      (in_tdata[COL_W +: TIME_W]),
    .old_i      (deadline_r[row_ptr_r]),
    .dt_i       (dt_r),
    .res        (dl_res),
    .deadline_o (dl_deadline)
  );

  // A fresh change can only pass at once when the debounce time is zero.
  assign commit     = (state_r == ST_TIME) && dl_res.done;
  assign passed     = changed_r ? (dt_r == '0) : (pending_r[row_ptr_r] && dl_res.expired);
  assign stable_new = passed ? col_r : stable_r[row_ptr_r];
  assign diff_new   = stable_new ^ reported_r[row_ptr_r];

  // Column walk: one column per cycle, hold on a set bit until the output is free.
  assign diff_rest = diff_sr_r >> 1;
  assign out_free  = !out_valid_r || out_tready;
  assign scan_step = !diff_sr_r[0] || out_free;
  assign out_load  = (state_r == ST_SCAN) && diff_sr_r[0] && out_free;
  assign row_next  = (row_ptr_r == ROW_IW'(ROWS - 1)) ? '0 : row_ptr_r + 1'b1;

  always_comb begin
    state_nxt   = state_r;
    row_ptr_nxt = row_ptr_r;
    diff_sr_nxt = diff_sr_r;
    stab_sr_nxt = stab_sr_r;
    col_cnt_nxt = col_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_TIME;
        end
      end
      ST_TIME: begin
        if (dl_res.done) begin
          diff_sr_nxt = diff_new;
          stab_sr_nxt = stable_new;
          col_cnt_nxt = '0;
          if (diff_new != '0) begin
            state_nxt = ST_SCAN;
          end else begin
            // Nothing to report: advance and drop straight back to idle.
            state_nxt   = ST_IDLE;
            row_ptr_nxt = row_next;
          end
        end
      end
      ST_SCAN: begin
        if (scan_step) begin
          diff_sr_nxt = diff_rest;
          stab_sr_nxt = stab_sr_r >> 1;
          col_cnt_nxt = col_cnt_r + 1'b1;
          if (diff_rest == '0) begin
            state_nxt   = ST_IDLE;
            row_ptr_nxt = row_next;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_ptr_r   <= '0;
      dt_r        <= DT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_ptr_r   <= row_ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        dt_r <= cfg_data;
      end
    end
  end

  // Row table: store the sample on accept; settle deadline, pending, stable and reported at commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        sampled_r[i]  <= '0;
        stable_r[i]   <= '0;
        reported_r[i] <= '0;
        pending_r[i]  <= 1'b0;
        deadline_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        sampled_r[row_ptr_r] <= col_in;
      end
      if (commit) begin
        if (changed_r) begin
          deadline_r[row_ptr_r] <= dl_deadline;
        end
        pending_r[row_ptr_r]  <= !passed && (changed_r || pending_r[row_ptr_r]);
        stable_r[row_ptr_r]   <= stable_new;
        // Every differing column is reported in this step.
        reported_r[row_ptr_r] <= stable_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    diff_sr_r <= diff_sr_nxt;
    stab_sr_r <= stab_sr_nxt;
    col_cnt_r <= col_cnt_nxt;
    if (in_acc) begin
      col_r     <= col_in;
      changed_r <= (sampled_r[row_ptr_r] != col_in);
    end
    if (out_load) begin
      out_row_r   <= IDX_W'(row_ptr_r);
      out_col_r   <= IDX_W'(col_cnt_r);
      out_press_r <= stab_sr_r[0];
      out_last_r  <= (diff_rest == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_col_r, out_row_r};
  assign out_tuser  = out_press_r;
  assign out_tlast  = out_last_r;

  a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (diff_sr_r != '0))
    else $error("column walk running with no changed column left");

  a_scan_exit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && state_nxt == ST_IDLE) |-> (out_load && diff_rest == '0))
    else $error("column walk ended without loading the final event");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_ptr_r <= ROW_IW'(ROWS - 1))
    else $error("row pointer beyond row count");

  a_accept_to_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_TIME && !in_tready))
    else $error("accepted step did not start the deadline pass");

endmodule

[hw/rtl/kmsd_deadline_unit.sv]
// Digit-serial deadline unit: new deadline (now + debounce) and expiry of the old one.
`timescale 1ns / 1ps
module kmsd_deadline_unit
  import kmsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] now_i,
  input  logic [TIME_W-1:0] old_i,
  input  logic [DT_W-1:0]   dt_i,
  output dl_res_t           res,
  output logic [TIME_W-1:0] deadline_o
);

  logic [TIME_W-1:0] now_sr_r, now_sr_nxt;
  logic [TIME_W-1:0] old_sr_r, old_sr_nxt;
  logic [TIME_W-1:0] sum_sr_r, sum_sr_nxt;
  logic              add_c_r, add_c_nxt;
  logic              sub_b_r, sub_b_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              expired_r, expired_nxt;

  logic [DIGIT_W-1:0] add_dig;
  logic [DIGIT_W:0]   add_res;
  logic [DIGIT_W:0]   sub_res;
  logic               last_dig;

  // The debounce time enters in the lowest digit only.
  assign add_dig  = (cnt_r == '0) ? DIGIT_W'(dt_i) : '0;
  assign add_res  = {1'b0, now_sr_r[DIGIT_W-1:0]} + {1'b0, add_dig} + (DIGIT_W+1)'(add_c_r);
  assign sub_res  = {1'b0, now_sr_r[DIGIT_W-1:0]} - {1'b0, old_sr_r[DIGIT_W-1:0]}
                    - (DIGIT_W+1)'(sub_b_r);
  assign last_dig = (cnt_r == DCNT_W'(N_DIGITS - 1));

  always_comb begin
    now_sr_nxt  = now_sr_r;
    old_sr_nxt  = old_sr_r;
    sum_sr_nxt  = sum_sr_r;
    add_c_nxt   = add_c_r;
    sub_b_nxt   = sub_b_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    expired_nxt = expired_r;
    if (start) begin
      now_sr_nxt = now_i;
      old_sr_nxt = old_i;
      add_c_nxt  = 1'b0;
      sub_b_nxt  = 1'b0;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      // Consume one digit of each operand, lowest first.
      now_sr_nxt = now_sr_r >> DIGIT_W;
      old_sr_nxt = old_sr_r >> DIGIT_W;
      sum_sr_nxt = {add_res[DIGIT_W-1:0], sum_sr_r[TIME_W-1:DIGIT_W]};
      add_c_nxt  = add_res[DIGIT_W];
      sub_b_nxt  = sub_res[DIGIT_W];
      cnt_nxt    = cnt_r + 1'b1;
      if (last_dig) begin
        busy_nxt    = 1'b0;
        done_nxt    = 1'b1;
        // Passed when the wrapped difference has its sign bit clear.
        expired_nxt = ~sub_res[DIGIT_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_sr_r  <= now_sr_nxt;
    old_sr_r  <= old_sr_nxt;
    sum_sr_r  <= sum_sr_nxt;
    add_c_r   <= add_c_nxt;
    sub_b_r   <= sub_b_nxt;
    expired_r <= expired_nxt;
  end

  assign res.done    = done_r;
  assign res.expired = expired_r;
  assign deadline_o  = sum_sr_r;

endmodule
